>>> rtl/sfp_pkg.sv
// Package: shared types and register indexes for the spherical flip point core.
`default_nettype none
package sfp_pkg;

  localparam int unsigned CoordBits = 32;
  localparam int unsigned CfgIdxBits = 2;

  localparam logic [CfgIdxBits-1:0] RegBallRadius = 2'd0;
  localparam logic [CfgIdxBits-1:0] RegCentreX    = 2'd1;
  localparam logic [CfgIdxBits-1:0] RegCentreY    = 2'd2;
  localparam logic [CfgIdxBits-1:0] RegCentreZ    = 2'd3;

  typedef struct packed {
    logic signed [CoordBits-1:0] point_x;
    logic signed [CoordBits-1:0] point_y;
    logic signed [CoordBits-1:0] point_z;
  } point_t;

  typedef struct packed {
    logic signed [CoordBits-1:0] flipped_x;
    logic signed [CoordBits-1:0] flipped_y;
    logic signed [CoordBits-1:0] flipped_z;
    logic                        saturated;
    logic                        at_centre;
  } flip_t;

endpackage
`default_nettype wire

>>> rtl/sfp_sqrt_pipe.sv
// Pipelined integer square root, one result bit per stage.
`default_nettype none
module sfp_sqrt_pipe #(
  parameter int unsigned InBits  = 68,
  parameter int unsigned OutBits = 34,
  parameter int unsigned TagBits = 8
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               valid_i,
  input  wire logic [InBits-1:0]  rad_i,
  input  wire logic [TagBits-1:0] tag_i,
  output logic                    valid_o,
  output logic [OutBits-1:0]      root_o,
  output logic [TagBits-1:0]      tag_o
);
  // The radicand is 2*OutBits wide; two radicand bits enter each stage.
  localparam int unsigned RemBits = OutBits + 2;

  logic [OutBits:0]      vld_q;
  logic [InBits-1:0]     rad_q  [OutBits];
  logic [OutBits-1:0]    rem_q  [OutBits];
  logic [OutBits-1:0]    root_q [OutBits+1];
  logic [TagBits-1:0]    tag_q  [OutBits+1];

  assign vld_q[0]  = valid_i;
  assign rad_q[0]  = rad_i;
  assign rem_q[0]  = '0;
  assign root_q[0] = '0;
  assign tag_q[0]  = tag_i;

  // Each stage brings down two radicand bits and subtracts 4*root+1 if it fits.
  for (genvar g = 0; g < OutBits; g++) begin : g_stage
    logic [RemBits-1:0] sh;
    logic [RemBits-1:0] trial;
    logic [RemBits-1:0] diff;
    logic               fit;
    assign sh    = {rem_q[g], rad_q[g][InBits-1 -: 2]};
    assign trial = {root_q[g], 2'b01};
    assign fit   = sh >= trial;
    assign diff  = sh - trial;
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[g+1] <= 1'b0;
      end else begin
        vld_q[g+1] <= vld_q[g];
      end
    end
    always_ff @(posedge clk_i) begin
      tag_q[g+1]  <= tag_q[g];
      root_q[g+1] <= {root_q[g][OutBits-2:0], fit};
    end
    // The partial remainder stays below 2^OutBits until the last stage.
    if (g < OutBits - 1) begin : g_fwd
      always_ff @(posedge clk_i) begin
        rad_q[g+1] <= {rad_q[g][InBits-3:0], 2'b00};
        rem_q[g+1] <= fit ? diff[OutBits-1:0] : sh[OutBits-1:0];
      end
    end
  end

  assign valid_o = vld_q[OutBits];
  assign root_o  = root_q[OutBits];
  assign tag_o   = tag_q[OutBits];
endmodule
`default_nettype wire

>>> rtl/sfp_div_pipe.sv
// Pipelined restoring divider, one quotient bit per stage, with rounding.
`default_nettype none
module sfp_div_pipe #(
  parameter int unsigned NumBits = 82,
  parameter int unsigned DenBits = 50,
  parameter int unsigned TagBits = 8
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               valid_i,
  input  wire logic [NumBits-1:0] num_i,
  input  wire logic [DenBits-1:0] den_i,
  input  wire logic [TagBits-1:0] tag_i,
  output logic                    valid_o,
  output logic [NumBits:0]        quot_o,
  output logic [TagBits-1:0]      tag_o
);
  localparam int unsigned RemBits = DenBits + 1;

  logic [NumBits:0]     vld_q;
  logic [NumBits-1:0]   num_q  [NumBits+1];
  logic [RemBits-1:0]   rem_q  [NumBits+1];
  logic [DenBits-1:0]   den_q  [NumBits+1];
  logic [TagBits-1:0]   tag_q  [NumBits+1];

  assign vld_q[0] = valid_i;
  assign num_q[0] = num_i;
  assign rem_q[0] = '0;
  assign den_q[0] = den_i;
  assign tag_q[0] = tag_i;

  // Each stage shifts in the next numerator bit and subtracts if it can.
  for (genvar g = 0; g < NumBits; g++) begin : g_stage
    logic [RemBits-1:0] sh;
    logic [RemBits-1:0] den_ext;
    logic               fit;
    assign sh      = {rem_q[g][RemBits-2:0], num_q[g][NumBits-1]};
    assign den_ext = {1'b0, den_q[g]};
    assign fit     = sh >= den_ext;
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[g+1] <= 1'b0;
      end else begin
        vld_q[g+1] <= vld_q[g];
      end
    end
    always_ff @(posedge clk_i) begin
      rem_q[g+1] <= fit ? sh - den_ext : sh;
      num_q[g+1] <= {num_q[g][NumBits-2:0], fit};
      den_q[g+1] <= den_q[g];
      tag_q[g+1] <= tag_q[g];
    end
  end

  // Round half away from zero: add one when twice the remainder reaches d.
  logic [RemBits:0] rem2;
  logic             rnd;
  assign rem2 = {rem_q[NumBits], 1'b0};
  assign rnd  = rem2 >= {2'b00, den_q[NumBits]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else begin
      valid_o <= vld_q[NumBits];
    end
  end
  always_ff @(posedge clk_i) begin
    quot_o <= {1'b0, num_q[NumBits]} + (NumBits+1)'(rnd);
    tag_o  <= tag_q[NumBits];
  end
endmodule
`default_nettype wire

>>> rtl/spherical_flip_point_core.sv
// Top level of the spherical flip point core: front end, sqrt, dividers, output.
//
//  channel | handshake           | payload
//  input   | start_i / busy_o    | point_i   (sfp_pkg::point_t)
//  config  | cfg_valid_i/ready_o | cfg_idx_i, cfg_data_i
//  result  | done_o strobe       | result_o  (sfp_pkg::flip_t)
//
// One item is accepted every cycle; busy_o stays low. done_o rises after the
// accepting edge once the item has passed three front stages, 34 square root
// stages, two stages for k and the products, 69 divider stages plus its
// rounding register, and the output register.
// Reset clears the valid bits and restores the register reset values.
// Results cannot be stalled, so nothing in the pipe ever waits.
`default_nettype none
module spherical_flip_point_core #(
  parameter int unsigned FRAC_BITS  = 16
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start_i,
  output logic                       busy_o,
  input  wire sfp_pkg::point_t       point_i,
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [1:0]            cfg_idx_i,
  input  wire logic [31:0]           cfg_data_i,
  output logic                       done_o,
  output sfp_pkg::flip_t             result_o
);
  import sfp_pkg::*;

  localparam int unsigned CB   = CoordBits;
  localparam int unsigned VB   = CB + 1;
  localparam int unsigned SB   = 2*VB + 2;
  localparam int unsigned DB   = SB / 2;
  localparam int unsigned KB   = DB + 2;
  localparam int unsigned NB   = VB + KB;
  localparam int unsigned TA   = 3*CB + 3*VB + 1;
  localparam int unsigned TD   = 3*CB + 4;
  localparam logic [CB-1:0] RadRst = CB'(10 << FRAC_BITS);

  // Configuration registers.
  logic [CB-2:0]        rad_q;
  logic signed [CB-1:0] cx_q, cy_q, cz_q;
  assign cfg_ready_o = 1'b1;
  assign busy_o      = 1'b0;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rad_q <= RadRst[CB-2:0];
      cx_q  <= '0;
      cy_q  <= '0;
      cz_q  <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_idx_i)
        RegBallRadius: rad_q <= cfg_data_i[CB-2:0];
        RegCentreX:    cx_q  <= cfg_data_i;
        RegCentreY:    cy_q  <= cfg_data_i;
        RegCentreZ:    cz_q  <= cfg_data_i;
        default:       ;
      endcase
    end
  end

  // Stage 1: differences from the centre.
  logic                 s1_v_q;
  logic signed [VB-1:0] s1_vx_q, s1_vy_q, s1_vz_q;
  logic signed [CB-1:0] s1_px_q, s1_py_q, s1_pz_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s1_v_q <= 1'b0;
    else         s1_v_q <= start_i;
  end
  always_ff @(posedge clk_i) begin
    s1_vx_q <= VB'(point_i.point_x) - VB'(cx_q);
    s1_vy_q <= VB'(point_i.point_y) - VB'(cy_q);
    s1_vz_q <= VB'(point_i.point_z) - VB'(cz_q);
    s1_px_q <= point_i.point_x;
    s1_py_q <= point_i.point_y;
    s1_pz_q <= point_i.point_z;
  end

  // Stage 2: squares of the magnitudes.
  function automatic logic [VB-1:0] mag_f(input logic signed [VB-1:0] a);
    mag_f = a[VB-1] ? VB'(-a) : a;
  endfunction
  logic            s2_v_q;
  logic [2*VB-1:0] s2_qx_q, s2_qy_q, s2_qz_q;
  logic [TA-2:0]   s2_tag_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s2_v_q <= 1'b0;
    else         s2_v_q <= s1_v_q;
  end
  always_ff @(posedge clk_i) begin
    s2_qx_q <= mag_f(s1_vx_q) * mag_f(s1_vx_q);
    s2_qy_q <= mag_f(s1_vy_q) * mag_f(s1_vy_q);
    s2_qz_q <= mag_f(s1_vz_q) * mag_f(s1_vz_q);
    s2_tag_q <= {s1_px_q, s1_py_q, s1_pz_q, s1_vx_q, s1_vy_q, s1_vz_q};
  end

  // Stage 3: sum of squares; the lowest tag bit marks a point on the centre.
  logic             s3_v_q;
  logic [SB-1:0]    s3_s_q;
  logic [TA-1:0]    s3_tag_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s3_v_q <= 1'b0;
    else         s3_v_q <= s2_v_q;
  end
  always_ff @(posedge clk_i) begin
    s3_s_q   <= SB'(s2_qx_q) + SB'(s2_qy_q) + SB'(s2_qz_q);
    s3_tag_q <= {s2_tag_q, (s2_qx_q | s2_qy_q | s2_qz_q) == '0};
  end

  // Square root.
  logic             sq_v;
  logic [DB-1:0]    sq_d;
  logic [TA-1:0]    sq_tag;
  sfp_sqrt_pipe #(.InBits(SB), .OutBits(DB), .TagBits(TA)) u_sqrt (
    .clk_i, .rst_ni, .valid_i(s3_v_q), .rad_i(s3_s_q), .tag_i(s3_tag_q),
    .valid_o(sq_v), .root_o(sq_d), .tag_o(sq_tag)
  );

  // Stage 4: k = 2R - d.
  logic                 s4_v_q;
  logic signed [KB-1:0] s4_k_q;
  logic [DB-1:0]        s4_d_q;
  logic [TA-1:0]        s4_tag_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s4_v_q <= 1'b0;
    else         s4_v_q <= sq_v;
  end
  always_ff @(posedge clk_i) begin
    s4_k_q   <= KB'({rad_q, 1'b0}) - KB'(sq_d);
    s4_d_q   <= (sq_d == '0) ? DB'(1) : sq_d;
    s4_tag_q <= sq_tag;
  end

  // Stage 5: numerators |v|*|k| for each axis.
  logic                 s4_kn;
  logic [KB-1:0]        s4_km;
  logic signed [VB-1:0] t4_vx, t4_vy, t4_vz;
  assign s4_kn = s4_k_q[KB-1];
  assign s4_km = s4_kn ? KB'(-s4_k_q) : s4_k_q;
  assign t4_vx = s4_tag_q[3*VB:2*VB+1];
  assign t4_vy = s4_tag_q[2*VB:VB+1];
  assign t4_vz = s4_tag_q[VB:1];
  logic             s5_v_q;
  logic [NB-1:0]    s5_nx_q, s5_ny_q, s5_nz_q;
  logic [DB-1:0]    s5_d_q;
  logic [TD-1:0]    s5_tag_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s5_v_q <= 1'b0;
    else         s5_v_q <= s4_v_q;
  end
  always_ff @(posedge clk_i) begin
    s5_nx_q  <= NB'(mag_f(t4_vx)) * NB'(s4_km);
    s5_ny_q  <= NB'(mag_f(t4_vy)) * NB'(s4_km);
    s5_nz_q  <= NB'(mag_f(t4_vz)) * NB'(s4_km);
    s5_d_q   <= s4_d_q;
    s5_tag_q <= {s4_tag_q[TA-1:3*VB+1],
                 t4_vx[VB-1] ^ s4_kn, t4_vy[VB-1] ^ s4_kn, t4_vz[VB-1] ^ s4_kn,
                 s4_tag_q[0]};
  end

  // Three dividers share one tag stream on the x lane.
  logic          dv_v, dv_vy, dv_vz;
  logic [NB:0]   qx, qy, qz;
  logic [TD-1:0] dv_tag, dv_tag_y, dv_tag_z;
  sfp_div_pipe #(.NumBits(NB), .DenBits(DB), .TagBits(TD)) u_div_x (
    .clk_i, .rst_ni, .valid_i(s5_v_q), .num_i(s5_nx_q), .den_i(s5_d_q),
    .tag_i(s5_tag_q), .valid_o(dv_v), .quot_o(qx), .tag_o(dv_tag)
  );
  sfp_div_pipe #(.NumBits(NB), .DenBits(DB), .TagBits(TD)) u_div_y (
    .clk_i, .rst_ni, .valid_i(s5_v_q), .num_i(s5_ny_q), .den_i(s5_d_q),
    .tag_i(s5_tag_q), .valid_o(dv_vy), .quot_o(qy), .tag_o(dv_tag_y)
  );
  sfp_div_pipe #(.NumBits(NB), .DenBits(DB), .TagBits(TD)) u_div_z (
    .clk_i, .rst_ni, .valid_i(s5_v_q), .num_i(s5_nz_q), .den_i(s5_d_q),
    .tag_i(s5_tag_q), .valid_o(dv_vz), .quot_o(qz), .tag_o(dv_tag_z)
  );

  // Final stage: signed offset, add centre, saturate; a point on the centre passes through.
  localparam int unsigned WB = NB + 3;
  localparam logic signed [WB-1:0] SMax = WB'({1'b0, {(CB-1){1'b1}}});
  localparam logic signed [WB-1:0] SMin = -SMax - WB'(1);
  logic signed [CB-1:0] px, py, pz;
  logic nx, ny, nz, atc;
  assign px  = dv_tag[TD-1 -: CB];
  assign py  = dv_tag[TD-CB-1 -: CB];
  assign pz  = dv_tag[TD-2*CB-1 -: CB];
  assign nx  = dv_tag[3];
  assign ny  = dv_tag[2];
  assign nz  = dv_tag[1];
  assign atc = dv_tag[0];

  function automatic logic signed [WB-1:0] add_f(input logic signed [CB-1:0] c,
      input logic [NB:0] q, input logic n);
    logic signed [WB-1:0] o;
    o = WB'($signed({1'b0, q}));
    add_f = WB'(c) + (n ? -o : o);
  endfunction
  function automatic logic [CB:0] sat_f(input logic signed [WB-1:0] r);
    if (r > SMax)      sat_f = {1'b1, SMax[CB-1:0]};
    else if (r < SMin) sat_f = {1'b1, SMin[CB-1:0]};
    else               sat_f = {1'b0, r[CB-1:0]};
  endfunction

  logic [CB:0] rx, ry, rz;
  assign rx = sat_f(add_f(cx_q, qx, nx));
  assign ry = sat_f(add_f(cy_q, qy, ny));
  assign rz = sat_f(add_f(cz_q, qz, nz));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) done_o <= 1'b0;
    else         done_o <= dv_v & dv_vy & dv_vz;
  end
  always_ff @(posedge clk_i) begin
    if (atc) begin
      result_o <= {px, py, pz, 1'b0, 1'b1};
    end else begin
      result_o <= {rx[CB-1:0], ry[CB-1:0], rz[CB-1:0], rx[CB] | ry[CB] | rz[CB], 1'b0};
    end
  end

  logic unused;
  assign unused = ^{dv_tag_y, dv_tag_z};

  // Checks.
  a_lanes: assert property (@(posedge clk_i) disable iff (!rst_ni) dv_v == dv_vy)
    else $error("divider lanes out of step");
  a_rdy: assert property (@(posedge clk_i) disable iff (!rst_ni) !busy_o && cfg_ready_o)
    else $error("core stalled");
endmodule
`default_nettype wire

>>> bench/sfp_flip_checker.sv
// Checker for the spherical flip point core: predicts each flipped point and compares it.
module sfp_flip_checker (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic            busy_i,
  input  sfp_pkg::point_t point_i,
  input  logic            cfg_valid_i,
  input  logic            cfg_ready_i,
  input  logic [1:0]      cfg_idx_i,
  input  logic [31:0]     cfg_data_i,
  input  logic            done_i,
  input  sfp_pkg::flip_t  result_i,
  output int              fail_count_o,
  output int              pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import sfp_pkg::*;

  localparam logic signed [63:0] CoordMax = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [63:0] CoordMin = -64'sh0000_0000_8000_0000;
  localparam logic [127:0] OffsetCap = 128'h1 << 62;

  // Shadow copies of the block's registers.
  logic [30:0]        radius_q;
  logic signed [31:0] centre_q [3];

  flip_t flipped_fifo [$];

  // Flips one point about the current centre and radius.
  function automatic flip_t flip_point(point_t p);
    logic signed [63:0] pc [3];
    logic signed [63:0] vec [3];
    logic signed [63:0] kk;
    logic signed [63:0] off;
    logic signed [63:0] sum;
    logic signed [31:0] res [3];
    logic [127:0] mags [3];
    logic [127:0] sq;
    logic [127:0] root_est;
    logic [127:0] trial;
    logic [127:0] kmag;
    logic [127:0] num;
    logic [127:0] quo;
    logic [127:0] rem;
    logic sat;
    logic neg;
    flip_t o;
    pc[0] = 64'(p.point_x);
    pc[1] = 64'(p.point_y);
    pc[2] = 64'(p.point_z);
    sq = '0;
    sat = 1'b0;
    for (int i = 0; i < 3; i++) begin
      vec[i] = pc[i] - 64'(centre_q[i]);
      mags[i] = (vec[i] < 0) ? 128'(-vec[i]) : 128'(vec[i]);
      sq += mags[i] * mags[i];
    end
    // A point sitting on the centre passes straight through.
    if (sq == '0) begin
      o.flipped_x = p.point_x;
      o.flipped_y = p.point_y;
      o.flipped_z = p.point_z;
      o.saturated = 1'b0;
      o.at_centre = 1'b1;
      return o;
    end
    // Floor of the square root, one bit at a time.
    root_est = '0;
    for (int b = 52; b >= 0; b--) begin
      trial = root_est | (128'h1 << b);
      if (trial * trial <= sq) root_est = trial;
    end
    kk = $signed(64'(radius_q) << 1) - $signed(root_est[63:0]);
    kmag = (kk < 0) ? 128'(-kk) : 128'(kk);
    for (int i = 0; i < 3; i++) begin
      num = mags[i] * kmag;
      quo = num / root_est;
      rem = num % root_est;
      if (rem * 2 >= root_est) quo = quo + 1;
      if (quo > OffsetCap) quo = OffsetCap;
      neg = (vec[i] < 0) != (kk < 0);
      off = neg ? -$signed(quo[63:0]) : $signed(quo[63:0]);
      sum = 64'(centre_q[i]) + off;
      if (sum > CoordMax) begin
        sum = CoordMax;
        sat = 1'b1;
      end
      if (sum < CoordMin) begin
        sum = CoordMin;
        sat = 1'b1;
      end
      res[i] = sum[31:0];
    end
    o.flipped_x = res[0];
    o.flipped_y = res[1];
    o.flipped_z = res[2];
    o.saturated = sat;
    o.at_centre = 1'b0;
    return o;
  endfunction

  // Track register writes, predict accepted items and check results.
  always @(posedge clk_i or negedge rst_ni) begin
    flip_t exp_r;
    if (!rst_ni) begin
      radius_q <= 31'd655360;
      centre_q[0] <= '0;
      centre_q[1] <= '0;
      centre_q[2] <= '0;
      flipped_fifo.delete();
      fail_count_o <= 0;
      pending_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_idx_i)
          RegBallRadius: radius_q <= cfg_data_i[30:0];
          RegCentreX: centre_q[0] <= cfg_data_i;
          RegCentreY: centre_q[1] <= cfg_data_i;
          RegCentreZ: centre_q[2] <= cfg_data_i;
          default: ;
        endcase
      end
      if (start_i && !busy_i) flipped_fifo = {flipped_fifo, flip_point(point_i)};
      if (done_i) begin
        if (flipped_fifo.size() == 0) begin
          if (fail_count_o < 10) $display("ERROR: result with no item outstanding: %h", result_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          exp_r = flipped_fifo.pop_front();
          if (result_i.flipped_x !== exp_r.flipped_x || result_i.flipped_y !== exp_r.flipped_y ||
              result_i.flipped_z !== exp_r.flipped_z || result_i.saturated !== exp_r.saturated ||
              result_i.at_centre !== exp_r.at_centre) begin
            if (fail_count_o < 10)
              $display("ERROR: exp x=%h y=%h z=%h sat=%b ctr=%b got x=%h y=%h z=%h sat=%b ctr=%b",
                       exp_r.flipped_x, exp_r.flipped_y, exp_r.flipped_z, exp_r.saturated,
                       exp_r.at_centre, result_i.flipped_x, result_i.flipped_y,
                       result_i.flipped_z, result_i.saturated, result_i.at_centre);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      pending_o <= flipped_fifo.size();
    end
  end
endmodule

>>> bench/tb_spherical_flip_point_core.sv
// Testbench top for the spherical flip point core: stimulus, register writes and verdict.
module tb_spherical_flip_point_core;
  timeunit 1ns;
  timeprecision 1ps;
  import sfp_pkg::*;

  localparam int CycleLimit = 300000;
  localparam int DrainCycles = 250;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic busy_o;
  point_t point_i = '0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [1:0] cfg_idx_i = RegBallRadius;
  logic [31:0] cfg_data_i = '0;
  logic done_o;
  flip_t result_o;
  int fail_count;
  int pending;
  int cycles = 0;
  int idle_pct = 0;
  logic signed [31:0] centre_x, centre_y, centre_z;

  always #10 clk_i = ~clk_i;

  spherical_flip_point_core dut (
    .clk_i, .rst_ni, .start_i, .busy_o, .point_i, .cfg_valid_i, .cfg_ready_o,
    .cfg_idx_i, .cfg_data_i, .done_o, .result_o
  );

  sfp_flip_checker checker_u (
    .clk_i, .rst_ni, .start_i, .busy_i(busy_o), .point_i, .cfg_valid_i,
    .cfg_ready_i(cfg_ready_o), .cfg_idx_i, .cfg_data_i, .done_i(done_o), .result_i(result_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // Run-away guard.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Present one item and hold it until it is taken, idling beforehand at random.
  task automatic send_point(logic signed [31:0] x, logic signed [31:0] y, logic signed [31:0] z);
    logic held;
    if ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk_i);
    end
    start_i <= 1'b1;
    point_i <= '{x, y, z};
    do begin
      @(negedge clk_i);
      held = busy_o;
      @(posedge clk_i);
    end while (held);
  endtask

  // Let every outstanding item come back, then let the pipe empty.
  task automatic drain_pipe();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Present one register write and hold it until it is taken; the caller drops valid.
  task automatic write_reg(logic [1:0] idx, logic [31:0] data);
    logic rdy;
    cfg_valid_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    do begin
      @(negedge clk_i);
      rdy = cfg_ready_o;
      @(posedge clk_i);
    end while (!rdy);
  endtask

  task automatic set_config(logic [31:0] radius, logic [31:0] cx, logic [31:0] cy,
                            logic [31:0] cz);
    drain_pipe();
    write_reg(RegBallRadius, radius);
    write_reg(RegCentreX, cx);
    write_reg(RegCentreY, cy);
    write_reg(RegCentreZ, cz);
    cfg_valid_i <= 1'b0;
    centre_x = cx;
    centre_y = cy;
    centre_z = cz;
  endtask

  // Random configuration; some settings pin the extremes.
  task automatic random_config(int kind);
    case (kind % 4)
      0: set_config($urandom_range(32'h00FF_FFFF), 32'($signed($urandom_range(32'h1F_FFFF)) -
                    32'sh10_0000), $urandom() >> 8, -($urandom() >> 9));
      1: set_config(32'h0, $urandom(), $urandom(), $urandom());
      2: set_config(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, $urandom() >> 4);
      default: set_config($urandom(), $urandom(), $urandom(), $urandom());
    endcase
  endtask

  // About half of the points near the centre, the rest anywhere in range.
  task automatic random_point();
    int span;
    if ($urandom_range(1)) begin
      span = 1 << $urandom_range(24, 2);
      send_point(centre_x + $signed($urandom_range(2 * span)) - span,
                 centre_y + $signed($urandom_range(2 * span)) - span,
                 centre_z + $signed($urandom_range(2 * span)) - span);
    end else begin
      send_point($urandom(), $urandom(), $urandom());
    end
  endtask

  initial begin
    centre_x = '0;
    centre_y = '0;
    centre_z = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed items under the reset settings: centre, extremes, mirror, tiny offsets.
    send_point(0, 0, 0);
    send_point(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    send_point(-32'sh8000_0000, -32'sh8000_0000, -32'sh8000_0000);
    send_point(1, 0, 0);
    send_point(0, -1, 0);
    send_point(0, 0, 32'sh0014_0000);
    send_point(32'sh0030_0000, -32'sh0020_0000, 32'sh0001_0000);
    send_point(32'sh000A_0000, 0, 0);
    send_point(32'h5555_5555, 32'hAAAA_AAAA, 32'hFFFF_0000);

    // Centre near the ends of the range with the largest radius: clamping.
    set_config(32'h7FFF_FFFF, 32'h7FFF_0000, -32'sh7FFF_0000, 32'h0);
    send_point(32'h7FFF_0000, -32'sh7FFF_0000, 0);
    send_point(32'h7FFF_0001, -32'sh7FFF_0000, 0);
    send_point(32'h7FFF_0000, -32'sh7FFF_0001, 0);
    send_point(32'h7FFF_0000, -32'sh7FFF_0000, 1);
    send_point(-32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    send_point(32'sh7FFF_FFFF, -32'sh8000_0000, -32'sh8000_0000);

    // Zero radius: every point off the centre is mirrored through the centre.
    set_config(32'h0, 32'h0001_0000, 32'h0002_0000, -32'sh0003_0000);
    send_point(32'h0001_0000, 32'h0002_0000, -32'sh0003_0000);
    send_point(32'h0001_0004, 32'h0002_0000, -32'sh0003_0000);
    send_point(32'h1234_5678, -32'sh0765_4321, 32'h0);

    // Random items in three idling phases, with several settings each.
    for (int ph = 0; ph < 3; ph++) begin
      idle_pct = (ph == 0) ? 12 : (ph == 1) ? 46 : 0;
      for (int cfg = 0; cfg < 4; cfg++) begin
        random_config(ph * 4 + cfg + ph);
        repeat (33) random_point();
      end
    end

    drain_pipe();
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
